@@ hdl/idmh_pkg.sv @@
// Package for the indexed d-ary min-heap unit.
// Holds the command and status codes, the heap entry and result types and the
// sequencer states. No dependencies.
package idmh_pkg;

  // Input commands
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int ItemW  = 8;
  localparam int KeyW   = 32;
  localparam int CountW = 9;

  // One heap slot: item id and its key
  typedef struct packed {
    logic [ItemW-1:0]       item;
    logic signed [KeyW-1:0] key;
  } entry_t;

  localparam int EntryW = ItemW + KeyW;

  // One result item
  typedef struct packed {
    logic [1:0]             status;
    logic [ItemW-1:0]       min_item;
    logic signed [KeyW-1:0] min_key;
    logic [CountW-1:0]      count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_POS,
    S_UP_ISSUE,
    S_UP_CMP,
    S_WR_FINAL,
    S_RM_ROOT,
    S_RM_LAST,
    S_DN_LEVEL,
    S_DN_ISSUE,
    S_DN_CMP,
    S_DN_DECIDE,
    S_DONE
  } state_e;

endpackage

@@ hdl/idmh_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the heap slots and the item position table. No dependencies.
module idmh_ram #(
  parameter int Depth = 256,
  parameter int Width = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/idmh_ctrl.sv @@
// Sequencer and shared key comparator of the indexed d-ary min-heap.
// Walks sift-up and sift-down one memory access at a time over two idmh_ram
// instances. Depends on idmh_pkg and idmh_ram.
module idmh_ctrl #(
  parameter int Items = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      log2_fanout_i,
  input  logic                            accept_i,
  input  logic [1:0]                      command_i,
  input  logic [idmh_pkg::ItemW-1:0]      item_i,
  input  logic signed [idmh_pkg::KeyW-1:0] key_i,
  output logic                            ready_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output idmh_pkg::result_t               res_o
);

  localparam int SlotW  = (Items > 1) ? $clog2(Items) : 1;
  localparam int CntW   = $clog2(Items + 1);
  localparam int ChildW = SlotW + 4;
  localparam int PosDepth = 1 << idmh_pkg::ItemW;

  idmh_pkg::state_e state_q, state_d;

  idmh_pkg::entry_t          cur_q, cur_d, best_q, best_d;
  logic [SlotW-1:0]          pos_q, pos_d, c_q, c_d, best_idx_q, best_idx_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [3:0]                j_q, j_d;
  logic [1:0]                status_q, status_d;
  logic [idmh_pkg::ItemW-1:0] min_item_q, min_item_d;
  logic signed [idmh_pkg::KeyW-1:0] min_key_q, min_key_d;
  logic [PosDepth-1:0]       valid_q, valid_d;

  // memory ports
  logic                      heap_we, pos_we;
  logic [SlotW-1:0]          heap_waddr, heap_raddr;
  idmh_pkg::entry_t          heap_wdata, heap_rdata;
  logic [idmh_pkg::ItemW-1:0] pos_waddr, pos_raddr;
  logic [SlotW-1:0]          pos_wdata, pos_rdata;

  idmh_ram #(.Depth(Items), .Width(idmh_pkg::EntryW)) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  idmh_ram #(.Depth(PosDepth), .Width(SlotW)) u_pos (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // Index arithmetic
  logic [SlotW-1:0]  parent_idx;
  logic [ChildW-1:0] child_c;
  logic [3:0]        fan_n;
  logic              child_end;
  logic              item_ok;
  logic              at_full;

  assign parent_idx = SlotW'(pos_q - 1'b1) >> log2_fanout_i;
  assign child_c    = (ChildW'(pos_q) << log2_fanout_i) + ChildW'(1) + ChildW'(j_q);
  assign fan_n      = 4'd1 << log2_fanout_i;
  assign child_end  = (j_q == fan_n) || (child_c >= ChildW'(cnt_q));
  assign item_ok    = 32'(item_i) < 32'(Items);
  assign at_full    = cnt_q == CntW'(Items);

  // Shared key comparator: a < b, signed
  logic signed [idmh_pkg::KeyW-1:0] cmp_a, cmp_b;
  logic lt;
  assign cmp_a = (state_q == idmh_pkg::S_UP_CMP) ? cur_q.key : heap_rdata.key;
  assign cmp_b = (state_q == idmh_pkg::S_UP_CMP) ? heap_rdata.key : best_q.key;
  assign lt    = cmp_a < cmp_b;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      idmh_pkg::S_IDLE: begin
        if (accept_i) begin
          state_d = idmh_pkg::S_DONE;
          if (command_i == idmh_pkg::CMD_UPDATE && item_ok) begin
            if (valid_q[item_i]) begin
              state_d = idmh_pkg::S_UPD_POS;
            end else if (!at_full) begin
              state_d = idmh_pkg::S_UP_ISSUE;
            end
          end else if (command_i == idmh_pkg::CMD_REMOVE && cnt_q != '0) begin
            state_d = idmh_pkg::S_RM_ROOT;
          end
        end
      end
      idmh_pkg::S_UPD_POS:  state_d = idmh_pkg::S_UP_ISSUE;
      idmh_pkg::S_UP_ISSUE: begin
        state_d = (pos_q == '0) ? idmh_pkg::S_WR_FINAL : idmh_pkg::S_UP_CMP;
      end
      idmh_pkg::S_UP_CMP: begin
        state_d = lt ? idmh_pkg::S_UP_ISSUE : idmh_pkg::S_WR_FINAL;
      end
      idmh_pkg::S_WR_FINAL: state_d = idmh_pkg::S_DONE;
      idmh_pkg::S_RM_ROOT:  state_d = idmh_pkg::S_RM_LAST;
      idmh_pkg::S_RM_LAST: begin
        state_d = (cnt_q == '0) ? idmh_pkg::S_DONE : idmh_pkg::S_DN_LEVEL;
      end
      idmh_pkg::S_DN_LEVEL: state_d = idmh_pkg::S_DN_ISSUE;
      idmh_pkg::S_DN_ISSUE: begin
        state_d = child_end ? idmh_pkg::S_DN_DECIDE : idmh_pkg::S_DN_CMP;
      end
      idmh_pkg::S_DN_CMP:   state_d = idmh_pkg::S_DN_ISSUE;
      idmh_pkg::S_DN_DECIDE: begin
        state_d = (best_idx_q == pos_q) ? idmh_pkg::S_WR_FINAL : idmh_pkg::S_DN_LEVEL;
      end
      idmh_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = idmh_pkg::S_IDLE;
        end
      end
      default: state_d = idmh_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cur_d      = cur_q;
    best_d     = best_q;
    pos_d      = pos_q;
    c_d        = c_q;
    best_idx_d = best_idx_q;
    cnt_d      = cnt_q;
    j_d        = j_q;
    status_d   = status_q;
    min_item_d = min_item_q;
    min_key_d  = min_key_q;
    valid_d    = valid_q;
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = cur_q;
    heap_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = cur_q.item;
    pos_wdata  = pos_q;
    pos_raddr  = item_i;
    case (state_q)
      idmh_pkg::S_IDLE: begin
        if (accept_i) begin
          status_d   = idmh_pkg::ST_OK;
          min_item_d = '0;
          min_key_d  = '0;
          cur_d.item = item_i;
          cur_d.key  = key_i;
          case (command_i)
            idmh_pkg::CMD_UPDATE: begin
              if (item_ok && !valid_q[item_i]) begin
                if (at_full) begin
                  status_d = idmh_pkg::ST_FULL;
                end else begin
                  // append as new last entry
                  pos_d            = SlotW'(cnt_q);
                  cnt_d            = cnt_q + 1'b1;
                  valid_d[item_i]  = 1'b1;
                end
              end
            end
            idmh_pkg::CMD_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = idmh_pkg::ST_EMPTY;
              end
            end
            idmh_pkg::CMD_CLEAR: begin
              cnt_d   = '0;
              valid_d = '0;
            end
            default: ;
          endcase
        end
      end
      idmh_pkg::S_UPD_POS: pos_d = pos_rdata;
      idmh_pkg::S_UP_ISSUE: begin
        heap_raddr = parent_idx;
        c_d        = parent_idx;
      end
      idmh_pkg::S_UP_CMP: begin
        // parent moves down into the hole
        if (lt) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.item;
          pos_d      = c_q;
        end
      end
      idmh_pkg::S_WR_FINAL: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      idmh_pkg::S_RM_ROOT: begin
        min_item_d               = heap_rdata.item;
        min_key_d                = heap_rdata.key;
        valid_d[heap_rdata.item] = 1'b0;
        heap_raddr               = SlotW'(cnt_q - 1'b1);
        cnt_d                    = cnt_q - 1'b1;
      end
      idmh_pkg::S_RM_LAST: begin
        cur_d = heap_rdata;
        pos_d = '0;
      end
      idmh_pkg::S_DN_LEVEL: begin
        best_d     = cur_q;
        best_idx_d = pos_q;
        j_d        = '0;
      end
      idmh_pkg::S_DN_ISSUE: begin
        heap_raddr = child_c[SlotW-1:0];
        c_d        = child_c[SlotW-1:0];
      end
      idmh_pkg::S_DN_CMP: begin
        // strict less keeps the first smallest child
        if (lt) begin
          best_d     = heap_rdata;
          best_idx_d = c_q;
        end
        j_d = j_q + 4'd1;
      end
      idmh_pkg::S_DN_DECIDE: begin
        if (best_idx_q != pos_q) begin
          heap_we    = 1'b1;
          heap_wdata = best_q;
          pos_we     = 1'b1;
          pos_waddr  = best_q.item;
          pos_d      = best_idx_q;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idmh_pkg::S_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    best_q     <= best_d;
    pos_q      <= pos_d;
    c_q        <= c_d;
    best_idx_q <= best_idx_d;
    j_q        <= j_d;
    status_q   <= status_d;
    min_item_q <= min_item_d;
    min_key_q  <= min_key_d;
  end

  // Outputs
  assign ready_o          = state_q == idmh_pkg::S_IDLE;
  assign res_valid_o      = state_q == idmh_pkg::S_DONE;
  assign res_o.status     = status_q;
  assign res_o.min_item   = min_item_q;
  assign res_o.min_key    = min_key_q;
  assign res_o.count      = idmh_pkg::CountW'(cnt_q);

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(Items))
    else $error("entry count above capacity");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == idmh_pkg::S_IDLE |-> $countones(valid_q) == 32'(cnt_q))
    else $error("present items do not match entry count");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && command_i == idmh_pkg::CMD_CLEAR |=> cnt_q == '0 && valid_q == '0)
    else $error("clear left entries");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && command_i == idmh_pkg::CMD_REMOVE && cnt_q == '0
    |=> status_q == idmh_pkg::ST_EMPTY)
    else $error("remove on empty heap not flagged");

endmodule

@@ hdl/indexed_dary_min_heap_unit.sv @@
// Indexed d-ary min-heap: one item per command, one result per item. An update
// moves the entry up the heap level by level. A remove takes out the root, moves
// the last entry to the root and sifts it down, reading each child in turn at every
// level visited. The pace of each command is set by the single read port of the heap
// slot memory, used once per step by the sequencer. The next item is taken while a
// result waits in the output register.
// Depends on idmh_pkg and idmh_ctrl.
module indexed_dary_min_heap_unit #(
  parameter int ITEMS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [idmh_pkg::ItemW-1:0]       item_i,
  input  logic signed [idmh_pkg::KeyW-1:0] key_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [idmh_pkg::ItemW-1:0]       min_item_o,
  output logic signed [idmh_pkg::KeyW-1:0] min_key_o,
  output logic [idmh_pkg::CountW-1:0]      count_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_log2_fanout_i
);

  logic              ctrl_ready, res_valid, res_ready, accept;
  idmh_pkg::result_t res;
  logic [1:0]        fanout_q;
  logic              out_valid_q;
  idmh_pkg::result_t out_q;

  assign accept      = in_valid_i && ctrl_ready;
  assign in_stall_o  = !ctrl_ready;
  assign cfg_ready_o = 1'b1;

  // Fanout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fanout_q <= 2'd1;
    end else if (cfg_valid_i) begin
      fanout_q <= cfg_log2_fanout_i;
    end
  end

  idmh_ctrl #(.Items(ITEMS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .log2_fanout_i (fanout_q),
    .accept_i      (accept),
    .command_i     (command_i),
    .item_i        (item_i),
    .key_i         (key_i),
    .ready_o       (ctrl_ready),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign min_item_o  = out_q.min_item;
  assign min_key_o   = out_q.min_key;
  assign count_o     = out_q.count;

endmodule

@@ tb/sv/tb.sv @@
// Testbench for indexed_dary_min_heap_unit: random and directed heap commands
// checked against a behavioral heap predictor. Depends on idmh_pkg and the RTL.
`timescale 1ns / 100ps
module tb;

  localparam int NITEMS = 256;
  localparam logic [1:0] CMD_RSVD = 2'd3;  // unused command code

  typedef struct packed {
    logic [1:0]                       command;
    logic [idmh_pkg::ItemW-1:0]       item;
    logic signed [idmh_pkg::KeyW-1:0] key;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [idmh_pkg::ItemW-1:0] item = '0;
  logic signed [idmh_pkg::KeyW-1:0] key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [idmh_pkg::ItemW-1:0] min_item;
  logic signed [idmh_pkg::KeyW-1:0] min_key;
  logic [idmh_pkg::CountW-1:0] count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_fanout = 2'd1;

  indexed_dary_min_heap_unit #(.ITEMS(NITEMS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .item_i(item), .key_i(key),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .min_item_o(min_item), .min_key_o(min_key), .count_o(count),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_log2_fanout_i(cfg_fanout)
  );

  initial forever #6 clk = ~clk;

  // Predictor state: heap slots, item positions, fanout
  logic signed [idmh_pkg::KeyW-1:0] hp_key [NITEMS];
  logic [idmh_pkg::ItemW-1:0]       hp_item [NITEMS];
  int unsigned                      pos_of [NITEMS];
  bit                               present [NITEMS];
  int unsigned                      n_entries;
  int unsigned                      fan_log2;

  cmd_item_t         pending_cmds[$];
  idmh_pkg::result_t expected_results[$];
  int errors = 0;
  bit quiet = 1'b0;       // no idling in the last part of the run
  bit hold_off = 1'b0;    // long receiver stall request
  int hold_cnt = 0;

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic void swap_slot(input int unsigned a, input int unsigned b);
    logic signed [idmh_pkg::KeyW-1:0] tk;
    logic [idmh_pkg::ItemW-1:0] ti;
    tk = hp_key[a]; ti = hp_item[a];
    hp_key[a] = hp_key[b]; hp_item[a] = hp_item[b];
    hp_key[b] = tk; hp_item[b] = ti;
    pos_of[hp_item[a]] = a;
    pos_of[hp_item[b]] = b;
  endfunction

  function automatic void climb(input int unsigned p);
    int unsigned up;
    while (p != 0) begin
      up = (p - 1) >> fan_log2;
      if (!(hp_key[p] < hp_key[up])) break;
      swap_slot(p, up);
      p = up;
    end
  endfunction

  function automatic void descend(input int unsigned p);
    int unsigned first, best, c;
    forever begin
      first = (p << fan_log2) + 1;
      best = p;
      for (int j = 0; j < (1 << fan_log2); j++) begin
        c = first + j;
        if (c < n_entries && hp_key[c] < hp_key[best]) best = c;
      end
      if (best == p) break;
      swap_slot(p, best);
      p = best;
    end
  endfunction

  function automatic idmh_pkg::result_t heap_step(input cmd_item_t c);
    idmh_pkg::result_t r;
    int unsigned p;
    r = '0;
    if (c.command == idmh_pkg::CMD_UPDATE) begin
      if (present[c.item]) begin
        p = pos_of[c.item];
        hp_key[p] = c.key;
        climb(p);
      end else if (n_entries >= NITEMS) begin
        r.status = idmh_pkg::ST_FULL;
      end else begin
        p = n_entries;
        hp_key[p] = c.key; hp_item[p] = c.item;
        pos_of[c.item] = p; present[c.item] = 1'b1;
        n_entries++;
        climb(p);
      end
    end else if (c.command == idmh_pkg::CMD_REMOVE) begin
      if (n_entries == 0) begin
        r.status = idmh_pkg::ST_EMPTY;
      end else begin
        swap_slot(0, n_entries - 1);
        r.min_item = hp_item[n_entries - 1];
        r.min_key = hp_key[n_entries - 1];
        present[r.min_item] = 1'b0;
        n_entries--;
        descend(0);
      end
    end else if (c.command == idmh_pkg::CMD_CLEAR) begin
      n_entries = 0;
      foreach (present[i]) present[i] = 1'b0;
    end
    r.count = n_entries[idmh_pkg::CountW-1:0];
    return r;
  endfunction

  // Driver: presents queued items, random idle bursts
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        // item taken: predict it and drop it from the queue
        if (in_valid) begin
          expected_results.insert(expected_results.size(), heap_step({command, item, key}));
          void'(pending_cmds.pop_front());
        end
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !(!quiet && $urandom_range(0, 9) == 0)) begin
          {command, item, key} <= pending_cmds[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (!quiet && pending_cmds.size() > 0) gap = $urandom_range(0, 3);
        end
      end
    end
  end

  // Monitor and receiver stall
  int ogap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        idmh_pkg::result_t got, want;
        got = {status, min_item, min_key, count};
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result %h", got));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d want %0d", got.status, want.status));
          if (got.min_item !== want.min_item)
            report($sformatf("min_item %0d want %0d", got.min_item, want.min_item));
          if (got.min_key !== want.min_key)
            report($sformatf("min_key %0d want %0d", got.min_key, want.min_key));
          if (got.count !== want.count)
            report($sformatf("count %0d want %0d", got.count, want.count));
        end
      end
      if (hold_off) begin
        hold_cnt++;
        out_stall <= 1'b1;
        if (hold_cnt >= 400) begin
          hold_off = 1'b0;
          hold_cnt = 0;
        end
      end else if (ogap > 0) begin
        ogap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        ogap = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] c, input logic [idmh_pkg::ItemW-1:0] it,
                          input logic signed [idmh_pkg::KeyW-1:0] k);
    cmd_item_t ci;
    ci = {c, it, k};
    pending_cmds.insert(pending_cmds.size(), ci);
  endtask

  // Wait until all items are taken and all results are back
  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_fanout(input logic [1:0] f);
    @(posedge clk);
    cfg_fanout <= f;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fan_log2 = f;
  endtask

  // Random phase: mostly inserts/updates over a small or full item range
  task automatic random_phase(input int n, input int item_max);
    int r;
    logic signed [idmh_pkg::KeyW-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
        k = $urandom();
      else
        k = idmh_pkg::KeyW'($signed($urandom_range(0, 40)) - 20);
      if (r < 55)
        push_cmd(idmh_pkg::CMD_UPDATE, idmh_pkg::ItemW'($urandom_range(0, item_max)), k);
      else if (r < 93)
        push_cmd(idmh_pkg::CMD_REMOVE, idmh_pkg::ItemW'($urandom()), $urandom());
      else if (r < 96)
        push_cmd(idmh_pkg::CMD_CLEAR, idmh_pkg::ItemW'($urandom()), $urandom());
      else
        push_cmd(CMD_RSVD, idmh_pkg::ItemW'($urandom()), $urandom());
    end
  endtask

  initial begin
    logic [1:0] fans [5] = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd1};
    n_entries = 0;
    fan_log2 = 1;
    foreach (present[i]) present[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty remove, key extremes, item extremes, ties, update, clear, unused
    push_cmd(idmh_pkg::CMD_REMOVE, 8'hff, 32'h0);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd0, 32'sh7fffffff);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd255, 32'sh80000000);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd17, 32'sd5);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd18, 32'sd5);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd19, -32'sd1);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd0, -32'sd7);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd255, 32'sh7fffffff);
    push_cmd(CMD_RSVD, 8'haa, 32'h55555555);
    repeat (7) push_cmd(idmh_pkg::CMD_REMOVE, 8'd0, 32'hffffffff);
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd3, 32'sd0);
    push_cmd(idmh_pkg::CMD_CLEAR, 8'd0, 32'd0);
    push_cmd(idmh_pkg::CMD_REMOVE, 8'd0, 32'd0);
    drain();

    // Fill the heap to all items, then over-insert one (present, so plain update)
    for (int i = 0; i < NITEMS; i++)
      push_cmd(idmh_pkg::CMD_UPDATE, idmh_pkg::ItemW'(i), $urandom());
    push_cmd(idmh_pkg::CMD_UPDATE, 8'd9, 32'sh80000000);
    hold_off = 1'b1;  // receiver holds off while the block backs up
    drain();
    for (int i = 0; i < NITEMS; i++) push_cmd(idmh_pkg::CMD_REMOVE, 8'd0, 32'd0);
    drain();

    foreach (fans[f]) begin
      set_fanout(fans[f]);
      if (f == 4) quiet = 1'b1;
      random_phase(130, (f % 2) ? 255 : 31);
      drain();
    end
    quiet = 1'b0;
    random_phase(80, 255);
    drain();
    quiet = 1'b1;
    random_phase(60, 63);
    drain();

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
